// File: design/mcct_pkg.sv
// Shared types and constants of the multi-channel compare timer.
`default_nettype none

package mcct_pkg;

  localparam int unsigned ActionW   = 3;
  localparam int unsigned ChannelW  = 3;
  localparam int unsigned AmountW   = 32;
  localparam int unsigned UnitW     = 2;
  localparam int unsigned KindW     = 2;
  localparam int unsigned ShiftW    = 4;
  localparam int unsigned PcountW   = 9;
  // Wide enough to hold any channel count in the supported range.
  localparam int unsigned ChanCmpW  = 4;

  localparam logic [ShiftW-1:0]  MaxShift   = 4'd9;
  localparam logic [ShiftW-1:0]  ResetShift = 4'd4;
  localparam logic [AmountW-1:0] ScaleUs    = 32'd1;
  localparam logic [AmountW-1:0] ScaleMs    = 32'd1000;
  localparam logic [AmountW-1:0] ScaleS     = 32'd1000000;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [ActionW-1:0] {
    ACT_TICK         = 3'd0,
    ACT_ARM_PERIODIC = 3'd1,
    ACT_ARM_SINGLE   = 3'd2,
    ACT_READ         = 3'd3,
    ACT_DELAY        = 3'd4
  } action_e;

  typedef enum logic [UnitW-1:0] {
    UNIT_US = 2'd0,
    UNIT_MS = 2'd1,
    UNIT_S  = 2'd2
  } unit_e;

  typedef enum logic [KindW-1:0] {
    EV_FIRED = 2'd0,
    EV_DELAY = 2'd1,
    EV_READ  = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ARM   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_DELAY = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic                 single;
    logic [ChannelW-1:0]  channel;
    logic [AmountW-1:0]   amount;   // already scaled to microseconds
  } cmd_t;

endpackage

`default_nettype wire

// File: design/mcct_front.sv
// Front end: decodes incoming transactions, scales amounts and drops no-ops.
`default_nettype none

module mcct_front import mcct_pkg::*; #(
  parameter int unsigned CHANNELS = 5
) (
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ActionW-1:0]  action_i,
  input  wire logic [ChannelW-1:0] channel_i,
  input  wire logic [AmountW-1:0]  amount_i,
  input  wire logic [UnitW-1:0]    unit_i,
  input  wire logic                q_full_i,
  output logic                     q_push_o,
  output cmd_t                     q_data_o
);

  logic               useful;
  logic [AmountW-1:0] factor;
  logic               chan_ok;

  assign chan_ok = ({1'b0, channel_i} < ChanCmpW'(CHANNELS));

  always_comb begin
    case (unit_e'(unit_i))
      UNIT_MS: factor = ScaleMs;
      UNIT_S:  factor = ScaleS;
      default: factor = ScaleUs;
    endcase
  end

  always_comb begin
    useful            = 1'b0;
    q_data_o.kind     = CMD_TICK;
    q_data_o.single   = 1'b0;
    q_data_o.channel  = channel_i;
    // Product is kept modulo 2^32, like the scaled amount itself.
    q_data_o.amount   = amount_i * factor;
    case (action_e'(action_i))
      ACT_TICK: begin
        useful        = 1'b1;
        q_data_o.kind = CMD_TICK;
      end
      ACT_ARM_PERIODIC, ACT_ARM_SINGLE: begin
        useful          = chan_ok;
        q_data_o.kind   = CMD_ARM;
        q_data_o.single = (action_e'(action_i) == ACT_ARM_SINGLE);
      end
      ACT_READ: begin
        useful        = 1'b1;
        q_data_o.kind = CMD_READ;
      end
      ACT_DELAY: begin
        useful        = 1'b1;
        q_data_o.kind = CMD_DELAY;
      end
      default: useful = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && useful;

endmodule

`default_nettype wire

// File: design/mcct_cmd_fifo.sv
// Short command queue between the front end and the execution back end.
`default_nettype none

module mcct_cmd_fifo import mcct_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      data_o,
  input  wire logic pop_i
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: design/mcct_back.sv
// Back end: counter, compare channels, delay channel and result serializer.
`default_nettype none

module mcct_back import mcct_pkg::*; #(
  parameter int unsigned CHANNELS     = 5,
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [ShiftW-1:0]       cfg_data_i,
  input  wire logic                    cmd_valid_i,
  input  wire cmd_t                    cmd_i,
  output logic                         cmd_pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [KindW-1:0]             event_kind_o,
  output logic [ChannelW-1:0]          fired_channel_o,
  output logic [COUNTER_BITS-1:0]      counter_value_o,
  output logic                         last_o
);

  localparam int unsigned CB = COUNTER_BITS;

  // Timer state.
  logic [ShiftW-1:0]   shift_q;
  logic [CB-1:0]       counter_q, counter_d;
  logic [PcountW-1:0]  pcount_q, pcount_d;
  logic [CB-1:0]       cmp_q [CHANNELS];
  logic [CB-1:0]       cmp_d [CHANNELS];
  logic [CB-1:0]       period_q [CHANNELS];
  logic [CB-1:0]       period_d [CHANNELS];
  logic [CHANNELS-1:0] single_q, single_d;
  logic [CHANNELS-1:0] en_q, en_d;
  logic [CB-1:0]       dly_cmp_q, dly_cmp_d;
  logic                dly_run_q, dly_run_d;

  // Results of the last executed command that are still to be sent.
  logic                pend_read_q, pend_read_d;
  logic                pend_dly_q, pend_dly_d;
  logic [CHANNELS-1:0] pend_mask_q, pend_mask_d;
  logic [CB-1:0]       pend_val_q, pend_val_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  event_kind_e         out_kind_q, out_kind_d;
  logic [ChannelW-1:0] out_chan_q, out_chan_d;
  logic [CB-1:0]       out_val_q, out_val_d;
  logic                out_last_q, out_last_d;

  logic                pend_busy, out_free, out_load, nxt_last, pend_done, exec;
  logic [CHANNELS-1:0] low_oh, mask_rest, match;
  logic [ChannelW-1:0] low_chan;
  logic [ShiftW-1:0]   sh_clip;
  logic [PcountW:0]    div;
  logic                advance;
  logic [CB-1:0]       cnt_next, amt;
  logic                dly_hit;

  assign pend_busy = pend_read_q || pend_dly_q || (pend_mask_q != '0);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = pend_busy && out_free;
  assign low_oh    = pend_mask_q & (~pend_mask_q + 1'b1);
  assign mask_rest = pend_mask_q & ~low_oh;

  always_comb begin
    low_chan = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (low_oh[i]) begin
        low_chan = ChannelW'(i);
      end
    end
  end

  always_comb begin
    if (pend_read_q) begin
      nxt_last = 1'b1;
    end else if (pend_dly_q) begin
      nxt_last = (pend_mask_q == '0);
    end else begin
      nxt_last = (mask_rest == '0);
    end
  end

  // A new command may start once the pending results drain this cycle.
  assign pend_done = out_load && nxt_last;
  assign exec      = cmd_valid_i && (!pend_busy || pend_done);
  assign cmd_pop_o = exec;

  assign sh_clip  = (shift_q > MaxShift) ? MaxShift : shift_q;
  assign div      = (PcountW + 1)'(1) << sh_clip;
  assign advance  = (({1'b0, pcount_q} + 1'b1) >= div);
  assign cnt_next = counter_q + 1'b1;
  assign amt      = cmd_i.amount[CB-1:0];
  assign dly_hit  = dly_run_q && (dly_cmp_q == cnt_next);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      match[i] = en_q[i] && (cmp_q[i] == cnt_next);
    end
  end

  always_comb begin
    counter_d   = counter_q;
    pcount_d    = pcount_q;
    cmp_d       = cmp_q;
    period_d    = period_q;
    single_d    = single_q;
    en_d        = en_q;
    dly_cmp_d   = dly_cmp_q;
    dly_run_d   = dly_run_q;
    pend_read_d = pend_read_q;
    pend_dly_d  = pend_dly_q;
    pend_mask_d = pend_mask_q;
    pend_val_d  = pend_val_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_chan_d  = out_chan_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;

    // Send the next pending result: read, then delay, then lowest channel.
    if (out_load) begin
      out_valid_d = 1'b1;
      out_val_d   = pend_val_q;
      out_last_d  = nxt_last;
      out_chan_d  = '0;
      if (pend_read_q) begin
        out_kind_d  = EV_READ;
        pend_read_d = 1'b0;
      end else if (pend_dly_q) begin
        out_kind_d = EV_DELAY;
        pend_dly_d = 1'b0;
      end else begin
        out_kind_d  = EV_FIRED;
        out_chan_d  = low_chan;
        pend_mask_d = mask_rest;
      end
    end

    if (exec) begin
      case (cmd_i.kind)
        CMD_TICK: begin
          if (advance) begin
            pcount_d = '0;
            counter_d = cnt_next;
            if (dly_hit) begin
              dly_run_d = 1'b0;
            end
            for (int i = 0; i < CHANNELS; i++) begin
              if (match[i]) begin
                if (single_q[i]) begin
                  en_d[i] = 1'b0;
                end else begin
                  cmp_d[i] = cmp_q[i] + period_q[i];
                end
              end
            end
            if (dly_hit || (match != '0)) begin
              pend_dly_d  = dly_hit;
              pend_mask_d = match;
              pend_val_d  = cnt_next;
            end
          end else begin
            pcount_d = pcount_q + 1'b1;
          end
        end
        CMD_ARM: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if ({1'b0, cmd_i.channel} == ChanCmpW'(i)) begin
              period_d[i] = amt;
              single_d[i] = cmd_i.single;
              en_d[i]     = 1'b1;
              cmp_d[i]    = counter_q + amt;
            end
          end
        end
        CMD_READ: begin
          pend_read_d = 1'b1;
          pend_val_d  = counter_q;
        end
        CMD_DELAY: begin
          dly_cmp_d = counter_q + amt;
          dly_run_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= ResetShift;
      counter_q   <= '0;
      pcount_q    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        cmp_q[i]    <= '0;
        period_q[i] <= '0;
      end
      single_q    <= '0;
      en_q        <= '0;
      dly_cmp_q   <= '0;
      dly_run_q   <= 1'b0;
      pend_read_q <= 1'b0;
      pend_dly_q  <= 1'b0;
      pend_mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        shift_q <= cfg_data_i;
      end
      counter_q   <= counter_d;
      pcount_q    <= pcount_d;
      cmp_q       <= cmp_d;
      period_q    <= period_d;
      single_q    <= single_d;
      en_q        <= en_d;
      dly_cmp_q   <= dly_cmp_d;
      dly_run_q   <= dly_run_d;
      pend_read_q <= pend_read_d;
      pend_dly_q  <= pend_dly_d;
      pend_mask_q <= pend_mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_val_q <= pend_val_d;
    out_kind_q <= out_kind_d;
    out_chan_q <= out_chan_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = out_kind_q;
  assign fired_channel_o = out_chan_q;
  assign counter_value_o = out_val_q;
  assign last_o          = out_last_q;

endmodule

`default_nettype wire

// File: design/multi_channel_compare_timer.sv
// Top level of the multi-channel compare timer.
`default_nettype none

// The block keeps a free-running microsecond counter that advances once every
// 2^prescale_shift tick transactions (prescale_shift written through cfg_we_i
// and cfg_data_i, values above 9 act as 9, reset value 4). Callback channels
// are armed periodic or one-shot with an amount in microseconds, milliseconds
// or seconds; the scaled amount wraps at 32 bits and the compare is the
// counter plus that amount. A delay request works the same way but reports
// completion only once. A channel or the delay reports when the counter steps
// onto its compare value, so an amount of zero fires only after a full wrap.
// Each tick reports the delay first and then the channels in ascending order;
// the final result of a transaction carries last_o. A read transaction
// returns the counter value. Input transactions are taken one per cycle
// while the queue is not full: the front end scales the amount with one
// multiplier and drops arm requests to nonexistent channels and unknown
// actions, and a four-entry command queue feeds the execution stage. The
// execution stage takes one command per cycle, except that a command that
// produces results holds it until its last result is loaded, since results
// leave through a single output register that a stall also holds. A tick
// without results thus sustains one transaction per cycle, and the queue
// absorbs short bursts of fired channels. The first result of a transaction
// passes through the queue, the pending results and the output register.
module multi_channel_compare_timer import mcct_pkg::*; #(
  parameter int unsigned CHANNELS     = 5,
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [ShiftW-1:0]       cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [ActionW-1:0]      action_i,
  input  wire logic [ChannelW-1:0]     channel_i,
  input  wire logic [AmountW-1:0]      amount_i,
  input  wire logic [UnitW-1:0]        unit_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [KindW-1:0]             event_kind_o,
  output logic [ChannelW-1:0]          fired_channel_o,
  output logic [COUNTER_BITS-1:0]      counter_value_o,
  output logic                         last_o
);

  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_wdata, q_rdata;

  // Decode and scale incoming transactions.
  mcct_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .channel_i  (channel_i),
    .amount_i   (amount_i),
    .unit_i     (unit_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  // The queue lets the front end keep accepting while results drain.
  mcct_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .pop_i   (q_pop)
  );

  // Timer state, compare logic and the result serializer.
  mcct_back #(
    .CHANNELS     (CHANNELS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_rdata),
    .cmd_pop_o       (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .fired_channel_o (fired_channel_o),
    .counter_value_o (counter_value_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// File: design/mcct_checker.sv
// Port-level checker for the multi-channel compare timer, with its bind.
`default_nettype none

module mcct_checker import mcct_pkg::*; #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic [KindW-1:0]        event_kind_o,
  input wire logic [ChannelW-1:0]     fired_channel_o,
  input wire logic [COUNTER_BITS-1:0] counter_value_o,
  input wire logic                    last_o
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_kind_o)
      && $stable(fired_channel_o) && $stable(counter_value_o) && $stable(last_o))
    else $error("stalled result changed");

  // A counter read always produces exactly one result.
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_READ) |-> last_o)
    else $error("counter read result not marked last");

  // Only fired-channel results carry a channel number.
  a_chan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != EV_FIRED) |-> (fired_channel_o == '0))
    else $error("channel number on a non-channel result");

  // Results of one tick leave back to back from the serializer.
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a burst of results");

  // Nothing is reported right after reset.
  a_reset_idle: assert property (@(posedge clk_i)
    !$past(rst_ni) && rst_ni |-> !out_valid_o)
    else $error("result present right after reset");

endmodule

bind multi_channel_compare_timer mcct_checker #(
  .COUNTER_BITS (COUNTER_BITS)
) u_mcct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .event_kind_o    (event_kind_o),
  .fired_channel_o (fired_channel_o),
  .counter_value_o (counter_value_o),
  .last_o          (last_o)
);

`default_nettype wire
